FILE: rtl/core/hsv2rgb_pkg.sv
// Package for the HSV to RGB converter: fixed-point widths, reciprocal
// constants, sector and component codes, input clamp helper.
// No dependencies.
`default_nettype none

package hsv2rgb_pkg;

    localparam int FRAC_BITS = 14;

    localparam int SV_W = FRAC_BITS + 1;
    localparam int K_W  = FRAC_BITS + 6;
    localparam int P_W  = SV_W + K_W;
    localparam int X_W  = P_W + 8;
    localparam int Y_W  = 12;
    localparam int SH_Y = 2 * FRAC_BITS + 2;

    localparam longint unsigned ONE    = 64'd1 << FRAC_BITS;
    localparam longint unsigned K_FULL = 64'd60 << FRAC_BITS;

    // hue offset: 92 * 360, makes every 16-bit hue positive
    localparam int HUE_W      = 17;
    localparam int HUE_OFFSET = 33120;

    // floor(u / 360) = (u * REC360) >> 24 for u < 74898
    localparam int REC360    = 46604;
    localparam int REC360_SH = 24;
    localparam int Q360_W    = 8;
    localparam int R360_PW   = HUE_W + 16;

    // floor(h / 60) = (h * REC60) >> 16 for h < 1489
    localparam int REC60    = 1093;
    localparam int REC60_SH = 16;
    localparam int R60_PW   = 20;

    // floor(y / 15) = (y * REC15) >> 20 for y < 74898
    localparam int REC15    = 69906;
    localparam int REC15_SH = 20;
    localparam int R15_PW   = Y_W + 17;

    localparam int DEG_W = 9;
    localparam int SEC_W = 3;
    localparam int REM_W = 6;

    localparam logic [SEC_W-1:0] SEC_Y_G = 3'd1;
    localparam logic [SEC_W-1:0] SEC_G_C = 3'd2;
    localparam logic [SEC_W-1:0] SEC_C_B = 3'd3;
    localparam logic [SEC_W-1:0] SEC_B_M = 3'd4;
    localparam logic [SEC_W-1:0] SEC_M_R = 3'd5;

    localparam int NUM_COMP = 4;
    localparam int CMP_V = 0;
    localparam int CMP_P = 1;
    localparam int CMP_Q = 2;
    localparam int CMP_T = 3;

    typedef logic [SV_W-1:0] unit_t;
    typedef logic [K_W-1:0]  kval_t;
    typedef logic [7:0]      chan_t;

    function automatic unit_t clamp_unit(input logic signed [15:0] x);
        logic signed [63:0] xe;
        unit_t              res;
        xe = 64'(x);
        if (xe < 0)
            res = '0;
        else if (xe > $signed(ONE))
            res = SV_W'(ONE);
        else
            res = SV_W'(xe);
        return res;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/hsv_to_rgb_converter.sv
// Top level of the HSV to RGB converter: hue wrap, sector split, weight
// terms, four component lanes and the sector permutation.
// Depends on hsv2rgb_pkg and hsv2rgb_chan.

// Converts one pixel per clock while the output is not stalled, fully
// pipelined: a transfer accepted on the input passes through all stages
// in order to the output. Each of the ten register stages holds a valid
// bit and moves whenever the stage after it can take data, so bubbles are
// squeezed out and a stalled output fills the pipeline before the input
// stalls. Hue is wrapped modulo 360, saturation and brightness are clamped
// to 0..1.0, and every channel is the exact floor of component * 255.
`default_nettype none

module hsv_to_rgb_converter
    import hsv2rgb_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [15:0] hue_degrees,
    input  wire logic [15:0] saturation,
    input  wire logic [15:0] brightness,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       red,
    output logic [7:0]       green,
    output logic [7:0]       blue
);

    localparam int NST = 10;

    logic [NST-1:0] vld_reg;
    logic [NST-1:0] vld_next;
    logic [NST-1:0] rdy;

    // stage 0
    logic [HUE_W-1:0]   u0_reg, u0_next;
    unit_t              s0_reg, v0_reg, s0_next, v0_next;
    // stage 1
    logic [HUE_W-1:0]   u1_reg;
    logic [Q360_W-1:0]  q1_reg, q1_next;
    unit_t              s1_reg, v1_reg;
    logic [R360_PW-1:0] qprod;
    // stage 2
    logic [DEG_W-1:0]   h2_reg, h2_next;
    unit_t              s2_reg, v2_reg;
    logic [HUE_W-1:0]   hdiff;
    // stage 3
    logic [DEG_W-1:0]   h3_reg;
    logic [SEC_W-1:0]   sec3_reg, sec3_next;
    unit_t              s3_reg, v3_reg;
    logic [R60_PW-1:0]  sprod;
    // stage 4
    logic [REM_W-1:0]   rem4_reg, rem4_next;
    logic [SEC_W-1:0]   sec4_reg;
    unit_t              s4_reg, v4_reg;
    logic [DEG_W-1:0]   rdiff;
    // stage 5
    kval_t              k5_reg [NUM_COMP];
    kval_t              k5_next [NUM_COMP];
    logic [SEC_W-1:0]   sec5_reg;
    unit_t              v5_reg;
    // stages 6 to 8 (lanes), sector rides alongside
    logic [SEC_W-1:0]   sec6_reg, sec7_reg, sec8_reg;
    chan_t              ch8 [NUM_COMP];
    // stage 9
    chan_t              red_reg, green_reg, blue_reg;
    chan_t              red_next, green_next, blue_next;

    always_comb
    begin
        rdy[NST-1] = !vld_reg[NST-1] || !out_stall;
        for (int i = NST - 2; i >= 0; i--)
            rdy[i] = !vld_reg[i] || rdy[i+1];
        vld_next[0] = rdy[0] ? in_valid : vld_reg[0];
        for (int i = 1; i < NST; i++)
            vld_next[i] = rdy[i] ? vld_reg[i-1] : vld_reg[i];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    // datapath
    always_comb
    begin
        u0_next = HUE_W'($signed(hue_degrees)) + HUE_W'(HUE_OFFSET);
        s0_next = clamp_unit(saturation);
        v0_next = clamp_unit(brightness);

        qprod   = R360_PW'(u0_reg) * R360_PW'(REC360);
        q1_next = qprod[REC360_SH +: Q360_W];

        hdiff   = u1_reg - HUE_W'(q1_reg) * HUE_W'(360);
        h2_next = hdiff[DEG_W-1:0];

        sprod     = R60_PW'(h2_reg) * R60_PW'(REC60);
        sec3_next = sprod[REC60_SH +: SEC_W];

        rdiff     = h3_reg - DEG_W'(sec3_reg) * DEG_W'(60);
        rem4_next = rdiff[REM_W-1:0];

        k5_next[CMP_V] = K_W'(K_FULL);
        k5_next[CMP_P] = K_W'(K_FULL) - K_W'(s4_reg) * K_W'(60);
        k5_next[CMP_Q] = K_W'(K_FULL) - K_W'(s4_reg) * K_W'(rem4_reg);
        k5_next[CMP_T] = K_W'(K_FULL)
                         - K_W'(s4_reg) * K_W'(REM_W'(60) - rem4_reg);

        case (sec8_reg)
            SEC_Y_G:
            begin
                red_next = ch8[CMP_Q]; green_next = ch8[CMP_V]; blue_next = ch8[CMP_P];
            end
            SEC_G_C:
            begin
                red_next = ch8[CMP_P]; green_next = ch8[CMP_V]; blue_next = ch8[CMP_T];
            end
            SEC_C_B:
            begin
                red_next = ch8[CMP_P]; green_next = ch8[CMP_Q]; blue_next = ch8[CMP_V];
            end
            SEC_B_M:
            begin
                red_next = ch8[CMP_T]; green_next = ch8[CMP_P]; blue_next = ch8[CMP_V];
            end
            SEC_M_R:
            begin
                red_next = ch8[CMP_V]; green_next = ch8[CMP_P]; blue_next = ch8[CMP_Q];
            end
            default:
            begin
                red_next = ch8[CMP_V]; green_next = ch8[CMP_T]; blue_next = ch8[CMP_P];
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            u0_reg <= u0_next;
            s0_reg <= s0_next;
            v0_reg <= v0_next;
        end
        if (rdy[1])
        begin
            u1_reg <= u0_reg;
            q1_reg <= q1_next;
            s1_reg <= s0_reg;
            v1_reg <= v0_reg;
        end
        if (rdy[2])
        begin
            h2_reg <= h2_next;
            s2_reg <= s1_reg;
            v2_reg <= v1_reg;
        end
        if (rdy[3])
        begin
            h3_reg   <= h2_reg;
            sec3_reg <= sec3_next;
            s3_reg   <= s2_reg;
            v3_reg   <= v2_reg;
        end
        if (rdy[4])
        begin
            rem4_reg <= rem4_next;
            sec4_reg <= sec3_reg;
            s4_reg   <= s3_reg;
            v4_reg   <= v3_reg;
        end
        if (rdy[5])
        begin
            for (int c = 0; c < NUM_COMP; c++)
                k5_reg[c] <= k5_next[c];
            sec5_reg <= sec4_reg;
            v5_reg   <= v4_reg;
        end
        if (rdy[6])
            sec6_reg <= sec5_reg;
        if (rdy[7])
            sec7_reg <= sec6_reg;
        if (rdy[8])
            sec8_reg <= sec7_reg;
        if (rdy[9])
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    for (genvar c = 0; c < NUM_COMP; c++)
    begin : g_lane
        hsv2rgb_chan u_chan
        (
            .clk (clk),
            .en  (rdy[8:6]),
            .v   (v5_reg),
            .k   (k5_reg[c]),
            .ch  (ch8[c])
        );
    end

    assign in_stall  = !rdy[0];
    assign out_valid = vld_reg[NST-1];
    assign red       = red_reg;
    assign green     = green_reg;
    assign blue      = blue_reg;

endmodule

`default_nettype wire

FILE: rtl/core/hsv2rgb_chan.sv
// One component lane: v * k, scale by 255 and divide by 60 * ONE^2.
// Three register stages. Depends on hsv2rgb_pkg.
`default_nettype none

module hsv2rgb_chan
    import hsv2rgb_pkg::*;
(
    input  wire logic       clk,
    input  wire logic [2:0] en,
    input  wire unit_t      v,
    input  wire kval_t      k,
    output chan_t           ch
);

    logic [P_W-1:0]    p_reg;
    logic [P_W-1:0]    p_next;
    logic [Y_W-1:0]    y_reg;
    logic [Y_W-1:0]    y_next;
    chan_t             ch_reg;
    chan_t             ch_next;
    logic [X_W-1:0]    x;
    logic [R15_PW-1:0] qprod;

    always_comb
    begin
        p_next  = P_W'(v) * P_W'(k);
        x       = (X_W'(p_reg) << 8) - X_W'(p_reg);
        y_next  = x[SH_Y +: Y_W];
        qprod   = R15_PW'(y_reg) * R15_PW'(REC15);
        ch_next = qprod[REC15_SH +: 8];
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
            p_reg <= p_next;
        if (en[1])
            y_reg <= y_next;
        if (en[2])
            ch_reg <= ch_next;
    end

    assign ch = ch_reg;

endmodule

`default_nettype wire

FILE: bench/hsv_rgb_checker.sv
// Checker for hsv_to_rgb_converter: watches both channels, predicts each pixel
// from the input transfer and compares red, green and blue in order.
// Depends on hsv2rgb_pkg.
`timescale 1ns / 1ps

module hsv_rgb_checker
    import hsv2rgb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [15:0] hue_degrees,
    input  logic [15:0] saturation,
    input  logic [15:0] brightness,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [7:0]  red,
    input  logic [7:0]  green,
    input  logic [7:0]  blue,
    output int          mismatch_count,
    output int          pixels_pending
);

    localparam longint unsigned UNIT = 64'd1 << FRAC_BITS;

    typedef struct packed {
        chan_t r;
        chan_t g;
        chan_t b;
    } pixel_t;

    pixel_t expected_pixels[$];

    function automatic longint unsigned to_unit(input logic signed [15:0] x);
        int xi;
        xi = x;
        if (xi < 0)
            return 0;
        if (longint'(xi) > longint'(UNIT))
            return UNIT;
        return longint'(xi);
    endfunction

    // floor(255 * v * (1 - s*w/60)) with exact integers
    function automatic chan_t channel_level(input longint unsigned v,
                                            input longint unsigned s,
                                            input longint unsigned w);
        longint unsigned k;
        longint unsigned num;
        longint unsigned den;
        longint unsigned lvl;
        k   = 60 * UNIT - s * w;
        num = v * k * 255;
        den = 60 * UNIT * UNIT;
        lvl = num / den;
        if (lvl > 255)
            lvl = 255;
        return chan_t'(lvl);
    endfunction

    function automatic pixel_t rgb_from_hsv(input logic signed [15:0] h_in,
                                            input logic signed [15:0] s_in,
                                            input logic signed [15:0] v_in);
        int               h;
        longint unsigned  s;
        longint unsigned  v;
        logic [SEC_W-1:0] sector;
        int               rem;
        chan_t            cv;
        chan_t            cp;
        chan_t            cq;
        chan_t            ct;
        pixel_t           px;
        h = int'(h_in) % 360;
        if (h < 0)
            h += 360;
        s      = to_unit(s_in);
        v      = to_unit(v_in);
        sector = SEC_W'(h / 60);
        rem    = h % 60;
        cv = channel_level(v, s, 0);
        cp = channel_level(v, s, 60);
        cq = channel_level(v, s, rem);
        ct = channel_level(v, s, 60 - rem);
        case (sector)
            SEC_Y_G: px = '{r: cq, g: cv, b: cp};
            SEC_G_C: px = '{r: cp, g: cv, b: ct};
            SEC_C_B: px = '{r: cp, g: cq, b: cv};
            SEC_B_M: px = '{r: ct, g: cp, b: cv};
            SEC_M_R: px = '{r: cv, g: cp, b: cq};
            default: px = '{r: cv, g: ct, b: cp};
        endcase
        return px;
    endfunction

    initial
    begin
        mismatch_count = 0;
        pixels_pending = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        pixel_t want;
        if (!rst_n)
        begin
            expected_pixels.delete();
            pixels_pending = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_pixels.size() == 0)
                begin
                    $error("output transfer with no pixel expected: %0d %0d %0d",
                           red, green, blue);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (red !== want.r)
                    begin
                        $error("red: expected %0d, got %0d", want.r, red);
                        mismatch_count++;
                    end
                    if (green !== want.g)
                    begin
                        $error("green: expected %0d, got %0d", want.g, green);
                        mismatch_count++;
                    end
                    if (blue !== want.b)
                    begin
                        $error("blue: expected %0d, got %0d", want.b, blue);
                        mismatch_count++;
                    end
                end
            end
            if (in_valid && !in_stall)
                expected_pixels.push_back(rgb_from_hsv(hue_degrees, saturation,
                                                       brightness));
            pixels_pending = expected_pixels.size();
        end
    end

endmodule

FILE: bench/tb.sv
// Top of the hsv_to_rgb_converter bench: clock, reset, pixel stimulus and
// output stall; the verdict comes from hsv_rgb_checker.
// Depends on hsv2rgb_pkg, hsv_to_rgb_converter and hsv_rgb_checker.
`timescale 1ns / 1ps

module tb;
    import hsv2rgb_pkg::*;

    localparam int HOLD_LEN = 300;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [15:0] hue_degrees = '0;
    logic [15:0] saturation = '0;
    logic [15:0] brightness = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;

    int mismatch_count;
    int pixels_pending;
    int gap_pct = 0;
    int stall_pct = 0;
    bit hold_req = 1'b0;
    int hold_count = 0;

    always #10 clk = ~clk;

    hsv_to_rgb_converter DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .hue_degrees(hue_degrees),
        .saturation (saturation),
        .brightness (brightness),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .red        (red),
        .green      (green),
        .blue       (blue)
    );

    hsv_rgb_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .hue_degrees   (hue_degrees),
        .saturation    (saturation),
        .brightness    (brightness),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .red           (red),
        .green         (green),
        .blue          (blue),
        .mismatch_count(mismatch_count),
        .pixels_pending(pixels_pending)
    );

    // random stalling, plus one long hold-off per run
    always @(posedge clk)
    begin
        if (hold_req && hold_count < HOLD_LEN)
        begin
            out_stall  <= 1'b1;
            hold_count <= hold_count + 1;
        end
        else
            out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end

    task automatic send_pixel(input logic [15:0] h, input logic [15:0] s,
                              input logic [15:0] v);
        while (gap_pct != 0 && $urandom_range(99) < gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        hue_degrees <= h;
        saturation  <= s;
        brightness  <= v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    function automatic logic [15:0] pick_level();
        logic [15:0] edges[7];
        edges = '{16'd0, 16'(ONE), 16'(ONE - 1), 16'(ONE + 1),
                  16'h8000, 16'h7FFF, 16'hFFFF};
        case ($urandom_range(9))
            0, 1:    return 16'($urandom);
            2, 3:    return edges[$urandom_range(6)];
            default: return 16'($urandom_range(0, ONE));
        endcase
    endfunction

    function automatic logic [15:0] pick_hue();
        if ($urandom_range(1))
            return 16'($urandom);
        return 16'($urandom_range(0, 1079) - 360);
    endfunction

    task automatic random_phase(input int count, input int gaps, input int stalls);
        gap_pct   = gaps;
        stall_pct = stalls;
        repeat (count)
            send_pixel(pick_hue(), pick_level(), pick_level());
    endtask

    initial
    begin
        int waited;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // sector boundaries, hue wrap, clamping and full value
        send_pixel(16'd0,     16'(ONE), 16'(ONE));
        send_pixel(16'd59,    16'(ONE), 16'(ONE));
        send_pixel(16'd60,    16'(ONE), 16'(ONE));
        send_pixel(16'd119,   16'(ONE), 16'd12000);
        send_pixel(16'd120,   16'd8192, 16'(ONE));
        send_pixel(16'd180,   16'd8192, 16'd8192);
        send_pixel(16'd240,   16'd4000, 16'd9000);
        send_pixel(16'd300,   16'(ONE), 16'd16383);
        send_pixel(16'd359,   16'd1,    16'(ONE));
        send_pixel(16'd360,   16'(ONE), 16'(ONE));
        send_pixel(-16'sd1,   16'(ONE), 16'(ONE));
        send_pixel(-16'sd360, 16'd9000, 16'd9000);
        send_pixel(-16'sd61,  16'd5000, 16'd15000);
        send_pixel(16'h8000,  16'(ONE), 16'(ONE));
        send_pixel(16'h7FFF,  16'(ONE), 16'(ONE));
        send_pixel(16'd30,    16'h8000, 16'd10000);
        send_pixel(16'd90,    16'hFFFF, 16'd10000);
        send_pixel(16'd150,   16'h7FFF, 16'd10000);
        send_pixel(16'd210,   16'(ONE + 1), 16'd10000);
        send_pixel(16'd270,   16'd10000, 16'h8000);
        send_pixel(16'd330,   16'd10000, 16'hFFFF);
        send_pixel(16'd45,    16'd10000, 16'h7FFF);
        send_pixel(16'd200,   16'd0,    16'(ONE + 1));
        send_pixel(16'd100,   16'd0,    16'd0);

        random_phase(100, 0, 0);
        random_phase(100, 56, 0);
        random_phase(100, 0, 56);
        random_phase(100, 15, 15);
        hold_req = 1'b1;
        random_phase(50, 0, 0);
        random_phase(60, 30, 30);

        in_valid  <= 1'b0;
        stall_pct = 0;
        waited    = 0;
        while (pixels_pending != 0 && waited < 5000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (20) @(posedge clk);
        if (pixels_pending != 0)
            $error("%0d pixels never arrived", pixels_pending);
        if (mismatch_count == 0 && pixels_pending == 0)
            $display("PASS hsv_to_rgb_converter");
        else
            $display("FAIL hsv_to_rgb_converter");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("FAIL hsv_to_rgb_converter");
        $finish;
    end

endmodule
